### src/prrt_pkg.sv
package prrt_pkg;

   localparam int DEFAULT_SLOT_COUNT = 8;

   localparam logic [15:0] EMPTY_REGISTER = 16'hFFFF;
   localparam logic [15:0] PERIOD_REMOVE  = 16'd0;
   localparam logic [15:0] PERIOD_ONCE    = 16'd1;
   localparam logic        ACTION_READ    = 1'b0;
   localparam logic        ACTION_POLL    = 1'b1;

   typedef enum logic [1:0] {
      KIND_SEND        = 2'd0,
      KIND_FULL        = 2'd1,
      KIND_NOT_IN_LIST = 2'd2
   } kind_type;

   // scan token handed from cell to cell
   typedef struct packed {
      logic        active;
      logic        match_hit;
      logic        free_hit;
      logic        due_hit;
      logic [15:0] due_reg;
      logic [15:0] due_per;
   } scan_token_type;

   typedef enum logic [2:0] {
      SLOT_NONE,
      SLOT_REMOVE,
      SLOT_RENEW,
      SLOT_INSERT,
      SLOT_STAMP
   } slot_op_type;

   typedef struct packed {
      slot_op_type op;
      logic [15:0] reg_number;
      logic [15:0] period;
      logic [31:0] deadline;
   } slot_write_type;

endpackage

### src/prrt_ifs.sv
interface prrt_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] reg_number;
   logic [15:0] period;
   logic [31:0] now;

   modport source (output valid, action, reg_number, period, now, input ready);
   modport sink (input valid, action, reg_number, period, now, output ready);
endinterface

interface prrt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] send_register;

   modport source (output valid, kind, send_register, input ready);
   modport sink (input valid, kind, send_register, output ready);
endinterface

### src/periodic_register_report_table.sv
// channel   dir  handshake     payload
// req       in   valid/ready   action, reg_number, period, now
// rsp       out  valid/ready   kind, send_register
//
// requests are taken one at a time, only in the idle state: the scan token walks
// the row of slot cells one cell per cycle, then the summary is latched and the
// decide state issues the slot update and loads the result register.
// a held result only stalls the block when the next transaction needs the
// output register. synchronous reset empties every slot.
module periodic_register_report_table
   import prrt_pkg::*;
#(
   parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT
) (
   input logic        clock,
   input logic        reset,
   prrt_req_if.sink   req,
   prrt_rsp_if.source rsp
);

   logic [15:0]    cmd_reg;
   logic [31:0]    cmd_now;
   slot_write_type wr;
   scan_token_type token [SLOT_COUNT+1];

   prrt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .cmd_reg     (cmd_reg),
      .cmd_now     (cmd_now),
      .token_start (token[0]),
      .token_end   (token[SLOT_COUNT]),
      .wr          (wr)
   );

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      prrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd_reg   (cmd_reg),
         .cmd_now   (cmd_now),
         .token_in  (token[i]),
         .token_out (token[i+1]),
         .wr        (wr)
      );
   end

endmodule

### src/prrt_cell.sv
module prrt_cell
   import prrt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [15:0]    cmd_reg,
   input  logic [31:0]    cmd_now,
   input  scan_token_type token_in,
   output scan_token_type token_out,
   input  slot_write_type wr
);

   logic           busy_ff;
   logic [15:0]    reg_ff;
   logic [15:0]    per_ff;
   logic [31:0]    deadline_ff;
   logic           mine_match_ff;
   logic           mine_free_ff;
   logic           mine_due_ff;
   scan_token_type token_ff;

   logic           is_match;
   logic           is_free;
   logic           is_due;
   scan_token_type token_in_next;

   assign is_match = busy_ff && (reg_ff == cmd_reg);
   assign is_free  = !busy_ff;
   assign is_due   = busy_ff && (per_ff != 16'd0) && (cmd_now >= deadline_ff);

   always_comb begin
      token_in_next = token_in;
      token_in_next.match_hit = token_in.match_hit | is_match;
      token_in_next.free_hit  = token_in.free_hit | is_free;
      if (!token_in.due_hit && is_due) begin
         token_in_next.due_hit = 1'b1;
         token_in_next.due_reg = reg_ff;
         token_in_next.due_per = per_ff;
      end
   end

   assign token_out = token_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         reg_ff        <= EMPTY_REGISTER;
         per_ff        <= 16'd0;
         deadline_ff   <= 32'd0;
         mine_match_ff <= 1'b0;
         mine_free_ff  <= 1'b0;
         mine_due_ff   <= 1'b0;
         token_ff      <= '0;
      end else begin
         token_ff <= token_in_next;
         // remember whether this cell is the first of its kind in the scan
         if (token_in.active) begin
            mine_match_ff <= is_match && !token_in.match_hit;
            mine_free_ff  <= is_free && !token_in.free_hit;
            mine_due_ff   <= is_due && !token_in.due_hit;
         end
         case (wr.op)
            SLOT_REMOVE: begin
               if (mine_match_ff) begin
                  busy_ff <= 1'b0;
                  reg_ff  <= EMPTY_REGISTER;
                  per_ff  <= 16'd0;
               end
            end
            SLOT_RENEW: begin
               if (mine_match_ff) per_ff <= wr.period;
            end
            SLOT_INSERT: begin
               if (mine_free_ff) begin
                  busy_ff <= 1'b1;
                  reg_ff  <= wr.reg_number;
                  per_ff  <= wr.period;
               end
            end
            SLOT_STAMP: begin
               if (mine_due_ff) deadline_ff <= wr.deadline;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

### src/prrt_ctrl.sv
module prrt_ctrl
   import prrt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   prrt_req_if.sink       req,
   prrt_rsp_if.source     rsp,
   output logic [15:0]    cmd_reg,
   output logic [31:0]    cmd_now,
   output scan_token_type token_start,
   input  scan_token_type token_end,
   output slot_write_type wr
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   state_type      state_ff;
   logic           start_ff;
   logic           action_ff;
   logic [15:0]    reg_ff;
   logic [15:0]    per_ff;
   logic [31:0]    now_ff;
   scan_token_type hits_ff;
   slot_write_type wr_ff;
   logic           rsp_valid_ff;
   kind_type       rsp_kind_ff;
   logic [15:0]    rsp_reg_ff;

   logic           need_rsp;
   kind_type       kind_in;
   logic [15:0]    send_in;
   slot_op_type    op_in;
   logic [32:0]    stamp_sum;
   logic [31:0]    stamp_in;
   logic           proceed;

   assign stamp_sum = {1'b0, now_ff} + {17'd0, hits_ff.due_per};
   assign stamp_in  = stamp_sum[32] ? 32'hFFFF_FFFF : stamp_sum[31:0];

   always_comb begin
      need_rsp = 1'b0;
      kind_in  = KIND_SEND;
      send_in  = 16'd0;
      op_in    = SLOT_NONE;
      if (action_ff == ACTION_POLL) begin
         if (hits_ff.due_hit) begin
            need_rsp = 1'b1;
            send_in  = hits_ff.due_reg;
            op_in    = SLOT_STAMP;
         end
      end else if (per_ff == PERIOD_REMOVE) begin
         if (hits_ff.match_hit) begin
            op_in = SLOT_REMOVE;
         end else begin
            need_rsp = 1'b1;
            kind_in  = KIND_NOT_IN_LIST;
         end
      end else if (per_ff == PERIOD_ONCE) begin
         need_rsp = 1'b1;
         send_in  = reg_ff;
      end else if (!hits_ff.free_hit) begin
         // full table wins even over a renewal
         need_rsp = 1'b1;
         kind_in  = KIND_FULL;
      end else if (hits_ff.match_hit) begin
         op_in = SLOT_RENEW;
      end else begin
         op_in = SLOT_INSERT;
      end
   end

   assign proceed = !need_rsp || !rsp_valid_ff || rsp.ready;

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.kind          = rsp_kind_ff;
   assign rsp.send_register = rsp_reg_ff;
   assign cmd_reg           = reg_ff;
   assign cmd_now           = now_ff;
   assign wr                = wr_ff;

   always_comb begin
      token_start        = '0;
      token_start.active = start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wr_ff.op     <= SLOT_NONE;
      end else begin
         start_ff <= 1'b0;
         wr_ff.op <= SLOT_NONE;
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  action_ff <= req.action;
                  reg_ff    <= req.reg_number;
                  per_ff    <= req.period;
                  now_ff    <= req.now;
                  start_ff  <= 1'b1;
                  state_ff  <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (token_end.active) begin
                  hits_ff  <= token_end;
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (proceed) begin
                  wr_ff.op         <= op_in;
                  wr_ff.reg_number <= reg_ff;
                  wr_ff.period     <= per_ff;
                  wr_ff.deadline   <= stamp_in;
                  if (need_rsp) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_kind_ff  <= kind_in;
                     rsp_reg_ff   <= send_in;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### test/tb_periodic_register_report_table.sv
module tb_periodic_register_report_table;
   import prrt_pkg::*;

   localparam int SLOTS = DEFAULT_SLOT_COUNT;
   localparam int POOL_SIZE = 12;
   localparam int RANDOM_ITEMS = 1330;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      kind_type    kind;
      logic [15:0] send_register;
   } report_type;

   // keeps its own copy of the slot table and the reports still owed
   class report_scoreboard;
      logic [15:0] slot_register [SLOTS];
      logic [15:0] slot_period [SLOTS];
      logic [31:0] slot_deadline [SLOTS];
      logic        slot_busy [SLOTS];
      report_type  expected_reports [$];
      int          mismatches;

      function void clear_table();
         for (int i = 0; i < SLOTS; i++) begin
            slot_register[i] = EMPTY_REGISTER;
            slot_period[i] = '0;
            slot_deadline[i] = '0;
            slot_busy[i] = 1'b0;
         end
         expected_reports.delete();
         mismatches = 0;
      endfunction

      function void note_transaction(logic action, logic [15:0] reg_number,
                                     logic [15:0] period, logic [31:0] now);
         int          hit;
         int          free_slot;
         int          due;
         logic [32:0] next_deadline;
         report_type  rpt;
         bit          reported;
         hit = -1;
         free_slot = -1;
         due = -1;
         reported = 1'b0;
         // scan downward so the lowest slot wins
         for (int i = SLOTS - 1; i >= 0; i--) begin
            if (slot_busy[i] && slot_register[i] == reg_number) hit = i;
            if (!slot_busy[i]) free_slot = i;
            if (slot_busy[i] && slot_period[i] != 0 && now >= slot_deadline[i]) due = i;
         end
         if (action == ACTION_POLL) begin
            if (due >= 0) begin
               next_deadline = {1'b0, now} + slot_period[due];
               slot_deadline[due] = next_deadline[32] ? '1 : next_deadline[31:0];
               rpt.kind = KIND_SEND;
               rpt.send_register = slot_register[due];
               reported = 1'b1;
            end
         end else if (period == PERIOD_REMOVE) begin
            if (hit < 0) begin
               rpt.kind = KIND_NOT_IN_LIST;
               rpt.send_register = '0;
               reported = 1'b1;
            end else begin
               // deadline stays as it was
               slot_register[hit] = EMPTY_REGISTER;
               slot_period[hit] = '0;
               slot_busy[hit] = 1'b0;
            end
         end else if (period == PERIOD_ONCE) begin
            rpt.kind = KIND_SEND;
            rpt.send_register = reg_number;
            reported = 1'b1;
         end else if (free_slot < 0) begin
            // full wins even over a renewal
            rpt.kind = KIND_FULL;
            rpt.send_register = '0;
            reported = 1'b1;
         end else if (hit >= 0) begin
            slot_period[hit] = period;
         end else begin
            slot_register[free_slot] = reg_number;
            slot_period[free_slot] = period;
            slot_busy[free_slot] = 1'b1;
         end
         if (reported) expected_reports.push_back(rpt);
      endfunction

      function void check_report(logic [1:0] kind, logic [15:0] send_register);
         report_type want;
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected report: kind %0d register %h", kind, send_register);
         end else begin
            want = expected_reports.pop_front();
            if (kind !== want.kind || send_register !== want.send_register) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("report mismatch: expected kind %0d register %h, got kind %0d register %h",
                           want.kind, want.send_register, kind, send_register);
            end
         end
      endfunction

      function int owed();
         return expected_reports.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   prrt_req_if req_ch ();
   prrt_rsp_if rsp_ch ();

   report_scoreboard sb;

   int tx_gap_pct;
   int rx_stall_pct;
   bit long_hold_pending;

   periodic_register_report_table #(
      .SLOT_COUNT(SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // monitors for both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_transaction(req_ch.action, req_ch.reg_number, req_ch.period, req_ch.now);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_report(rsp_ch.kind, rsp_ch.send_register);
      end
   end

   // receiver side: short stall bursts plus one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic offer_transaction(input logic action, input logic [15:0] reg_number,
                                    input logic [15:0] period, input logic [31:0] now);
      @(negedge clock);
      if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= action;
      req_ch.reg_number <= reg_number;
      req_ch.period <= period;
      req_ch.now <= now;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic read_req(input logic [15:0] reg_number, input logic [15:0] period);
      offer_transaction(ACTION_READ, reg_number, period, $urandom());
   endtask

   task automatic poll(input logic [31:0] now);
      offer_transaction(ACTION_POLL, 16'($urandom()), 16'($urandom()), now);
   endtask

   initial begin
      static logic [15:0] reg_pool [POOL_SIZE];
      logic [31:0] tick;
      logic [15:0] reg_pick;
      logic [15:0] per_pick;
      int          pick;
      int          waited;

      sb = new;
      sb.clear_table();
      tx_gap_pct = 20;
      rx_stall_pct = 20;
      long_hold_pending = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = ACTION_READ;
      req_ch.reg_number = '0;
      req_ch.period = '0;
      req_ch.now = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      read_req(16'h1234, PERIOD_REMOVE);       // remove from empty table
      read_req(EMPTY_REGISTER, PERIOD_REMOVE); // empty marker never matches a free slot
      read_req(16'h0000, PERIOD_ONCE);
      read_req(EMPTY_REGISTER, PERIOD_ONCE);
      poll(32'h0);                             // nothing busy
      read_req(EMPTY_REGISTER, 16'hFFFF);
      read_req(16'h0000, 16'd2);
      read_req(16'h0000, 16'd3);               // renew period
      poll(32'h0);
      poll(32'h0);
      poll(32'h2);
      poll(32'hFFFF_FFFF);                     // deadline saturates
      poll(32'hFFFF_FFFF);
      read_req(16'h0101, 16'd4);
      read_req(16'h0202, 16'd5);
      read_req(16'h0303, 16'd6);
      read_req(16'h0404, 16'd7);
      read_req(16'h0505, 16'd8);
      read_req(16'h0606, 16'h8000);            // table now full
      read_req(16'h0101, 16'd9);               // duplicate still reports full
      read_req(16'h7777, 16'd2);
      read_req(EMPTY_REGISTER, PERIOD_REMOVE);
      read_req(16'h1234, PERIOD_REMOVE);
      read_req(16'h8888, 16'h8000);            // reuses slot with its old deadline
      poll(32'hFFFF_FFFE);

      // random part
      reg_pool[0] = 16'h0000;
      reg_pool[1] = EMPTY_REGISTER;
      for (int i = 2; i < POOL_SIZE; i++) reg_pool[i] = 16'($urandom());
      tick = '0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 120 == 0) begin
            pick = $urandom_range(0, 2);
            tx_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 8 : 25;
            pick = $urandom_range(0, 2);
            rx_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 8 : 25;
         end
         if (n == 400) long_hold_pending = 1'b1;
         // keep the sender pushing while the receiver holds off
         if (n >= 400 && n < 500) tx_gap_pct = 0;
         if (n >= RANDOM_ITEMS - 150) begin
            tx_gap_pct = 0;
            rx_stall_pct = 0;
         end

         reg_pick = ($urandom_range(0, 9) == 0) ? 16'($urandom())
                                               : reg_pool[$urandom_range(0, POOL_SIZE - 1)];
         per_pick = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(2, 65535))
                                               : 16'($urandom_range(2, 60));
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if ($urandom_range(0, 49) == 0) tick = $urandom();
            else if ($urandom_range(0, 99) == 0) tick = 32'hFFFF_FFF0 - $urandom_range(0, 100);
            else tick = tick + $urandom_range(0, 40);
            poll(tick);
         end else if (pick < 70) begin
            read_req(reg_pick, per_pick);
         end else if (pick < 90) begin
            read_req(reg_pick, PERIOD_REMOVE);
         end else begin
            read_req(16'($urandom()), PERIOD_ONCE);
         end
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      waited = 0;
      while (sb.owed() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (sb.owed() != 0) begin
         $display("status: fail");
         $finish;
      end else begin
         repeat (SETTLE_CYCLES) @(posedge clock);
         if (sb.mismatches == 0 && sb.owed() == 0) begin
            $display("status: pass");
         end else begin
            $display("status: fail");
         end
         $finish;
      end
   end

   initial begin
      #5000000;
      $display("status: fail");
      $finish;
   end

endmodule
